/* rtl/core/stkt_pkg.sv */
// Shared types and constants for the sorted top-k score table unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package stkt_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int NUM_TABLES  = 4;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TBL_W       = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               used;
    logic [23:0]        name;
    logic signed [15:0] score;
  } slot_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               table_ok;
    logic [TBL_W-1:0]   tidx;
    logic signed [15:0] score;
    logic [23:0]        name;
    logic               read_ok;
    logic [SLOT_W-1:0]  ridx;
  } op_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic [7:0]         entry_char2;
    logic [7:0]         entry_char1;
    logic [7:0]         entry_char0;
    logic signed [15:0] entry_score;
    logic               entry_present;
    logic [2:0]         rank_position;
    logic               accepted;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/stkt_front.sv */
// Front end: accepts input items, decodes them into operations and holds them
// in a two-entry queue for the back end. Depends on stkt_pkg.
`default_nettype none

module stkt_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [stkt_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]                     s_tuser,
  output logic                                op_valid,
  output stkt_pkg::op_t                       op,
  input  wire logic                           op_pop
);
  import stkt_pkg::*;

  op_t        q [2];
  op_t        dec;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    dec.cmd      = cmd_t'(s_tuser);
    dec.table_ok = int'(s_tdata[1:0]) < NUM_TABLES;
    dec.tidx     = TBL_W'(s_tdata[1:0]);
    dec.score    = s_tdata[17:2];
    dec.name     = s_tdata[41:18];
    dec.read_ok  = int'(s_tdata[44:42]) < TABLE_DEPTH;
    dec.ridx     = SLOT_W'(s_tdata[44:42]);
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (op_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(op_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stkt_back.sv */
// Back end: holds every ranked table in parallel cells, runs one operation per
// cycle unless the output stalls, registers the result. Depends on stkt_pkg.
`default_nettype none

module stkt_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [3:0]                      lower_wins_mask,
  input  wire logic                            op_valid,
  input  wire stkt_pkg::op_t                   op,
  output logic                                 op_pop,
  output logic                                 m_valid,
  input  wire logic                            m_ready,
  output logic [stkt_pkg::OUT_DATA_W-1:0]      m_data
);
  import stkt_pkg::*;

  slot_t                  cells [NUM_TABLES][TABLE_DEPTH];
  slot_t                  row [TABLE_DEPTH];
  slot_t                  ins_row [TABLE_DEPTH];
  slot_t                  new_slot;
  slot_t                  rd_slot;
  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] used_bits [NUM_TABLES];
  logic [POS_W-1:0]       pos;
  logic                   place_ok;
  logic                   lower_wins;
  logic                   exec;
  result_t                res;
  result_t                res_next;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      row[i] = cells[op.tidx][i];
    end
  end

  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        used_bits[t][i] = cells[t][i].used;
      end
    end
  end

  assign lower_wins = (int'(op.tidx) < 4) && lower_wins_mask[2'(op.tidx)];

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i] = !row[i].used ||
               (lower_wins ? (op.score < row[i].score) : (op.score > row[i].score));
    end
    pos = POS_W'(TABLE_DEPTH);
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  assign place_ok = |hit;

  always_comb begin
    new_slot.used  = (op.name[7:0] != 8'd0);
    new_slot.name  = op.name;
    new_slot.score = op.score;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k < int'(pos)) begin
        ins_row[k] = row[k];
      end else if (k == int'(pos)) begin
        ins_row[k] = new_slot;
      end else begin
        ins_row[k] = row[(k > 0) ? k - 1 : 0];
      end
    end
  end

  assign rd_slot = row[op.ridx];

  always_comb begin
    res_next = '0;
    if (op.table_ok) begin
      unique case (op.cmd)
        CMD_INSERT, CMD_QUERY: begin
          if (place_ok) begin
            res_next.accepted      = 1'b1;
            res_next.rank_position = 3'(pos);
          end
        end
        CMD_READ: begin
          if (op.read_ok) begin
            res_next.entry_present = rd_slot.used;
            res_next.entry_score   = rd_slot.score;
            res_next.entry_char0   = rd_slot.name[7:0];
            res_next.entry_char1   = rd_slot.name[15:8];
            res_next.entry_char2   = rd_slot.name[23:16];
          end
        end
        default: begin
          res_next = '0;
        end
      endcase
    end
  end

  assign exec   = op_valid && (!m_valid || m_ready);
  assign op_pop = exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TABLES; t++) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          cells[t][i] <= '0;
        end
      end
    end else if (exec && op.table_ok) begin
      if (op.cmd == CMD_INSERT && place_ok) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          cells[op.tidx][i] <= ins_row[i];
        end
      end else if (op.cmd == CMD_CLEAR) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          cells[op.tidx][i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (exec) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res <= res_next;
    end
  end

  assign m_data = res;

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    exec && op.table_ok && op.cmd == CMD_CLEAR |=> used_bits[$past(op.tidx)] == '0)
    else $error("cleared table still holds a used slot");

  a_bad_table_zero: assert property (@(posedge clk) disable iff (rst)
    exec && !op.table_ok |=> m_valid && res == '0)
    else $error("command to a missing table gave a nonzero result");

  a_present_named: assert property (@(posedge clk) disable iff (rst)
    m_valid && res.entry_present |-> res.entry_char0 != 8'd0)
    else $error("present entry has an empty first character");

  a_exec_shows: assert property (@(posedge clk) disable iff (rst)
    exec |=> m_valid)
    else $error("executed operation produced no result");

endmodule

`default_nettype wire

/* rtl/core/sorted_top_k_score_table_unit.sv */
// Top level of the sorted top-k score table unit: configuration register,
// front-end decode queue and back-end table cells. Depends on stkt_pkg,
// stkt_front and stkt_back.
//
// The unit keeps four ranked tables of eight entries each, all in flip-flops
// that reset clears at once, so no clearing pass follows reset. The sustained
// rate is one item per cycle unless the output stalls: the back end compares
// the candidate with all cells of the addressed table at once and shifts them.
// An item passes the queue and then the result register on its way out. A
// two-entry queue separates input from execution, and a result register
// separates execution from the output, so each side may stall.
`default_nettype none

module sorted_top_k_score_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // table_select[1:0], new_score[17:2], new_char0[25:18], new_char1[33:26],
  // new_char2[41:34], read_index[44:42], zero[47:45]
  input  wire logic [47:0] s_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // accepted[0], rank_position[3:1], entry_present[4], entry_score[20:5],
  // entry_char0[28:21], entry_char1[36:29], entry_char2[44:37], zero[47:45]
  output logic [47:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);
  import stkt_pkg::*;

  logic [3:0] lower_wins_mask;
  logic       op_valid;
  logic       op_pop;
  op_t        op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_wins_mask <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      lower_wins_mask <= cfg_data;
    end
  end

  stkt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  stkt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .lower_wins_mask (lower_wins_mask),
    .op_valid        (op_valid),
    .op              (op),
    .op_pop          (op_pop),
    .m_valid         (m_tvalid),
    .m_ready         (m_tready),
    .m_data          (m_tdata)
  );

endmodule

`default_nettype wire
